/* sv/wlan_beacon_info_extractor_core_assert.svh */
// Assertion macros shared by the beacon extractor RTL.
// Each macro checks on the rising edge of clk_i and is off while rst_ni is low.
`ifndef WLAN_BEACON_INFO_EXTRACTOR_CORE_ASSERT_SVH
`define WLAN_BEACON_INFO_EXTRACTOR_CORE_ASSERT_SVH

// Property that must hold in the same cycle.
`define WBIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define WBIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/wbie_pkg.sv */
// Package for the beacon information extractor: sizes, element and radiotap codes,
// phase and status enums, and the summary and result structs. No dependencies.
package wbie_pkg;

  localparam int MaxFrameBytes   = 4096;
  localparam int SsidMax         = 32;
  localparam int SsidStoreDepth  = 32;
  localparam int SsidIdxW        = $clog2(SsidStoreDepth);
  localparam int PosW            = $clog2(MaxFrameBytes + 1);
  localparam int OutTdataW       = 40;

  localparam logic [7:0] ElementOffsetReset = 8'd36;
  localparam logic [7:0] ChannelDefault     = 8'd1;
  localparam logic signed [7:0] SignalDefault = -8'sd50;

  localparam logic [7:0] IeIdSsid = 8'd0;
  localparam logic [7:0] IeIdDs   = 8'd3;
  localparam logic [7:0] IeIdRsn  = 8'd48;

  localparam int RtBitDbmPower  = 5;
  localparam int RtBitAntSignal = 6;
  localparam int RtPresentW     = 7;
  localparam int RtFixedLen     = 8;

  localparam logic KindSummary = 1'b0;
  localparam logic KindSsid    = 1'b1;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_ID,
    PH_LEN,
    PH_BODY
  } wbie_phase_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_SHORT,
    STATUS_LONG
  } wbie_status_e;

  typedef struct packed {
    wbie_status_e      status;
    logic [5:0]        ssid_length;
    logic [7:0]        channel;
    logic signed [7:0] signal_dbm;
    logic              rsn_present;
  } wbie_summary_t;

  typedef struct packed {
    logic          kind;
    wbie_summary_t summary;
    logic [7:0]    ssid_byte;
    logic          last_result;
  } wbie_result_t;

  typedef logic [SsidStoreDepth-1:0][7:0] wbie_ssid_buf_t;

  // Byte position of the dBm power field, from the TSFT, flags, rate, channel
  // and FHSS present bits.
  function automatic logic [4:0] dbm_position(input logic [RtPresentW-1:0] p);
    dbm_position = 5'(RtFixedLen) + (p[0] ? 5'd8 : 5'd0) + {4'd0, p[1]} + {4'd0, p[2]}
                 + (p[3] ? 5'd4 : 5'd0) + (p[4] ? 5'd2 : 5'd0);
  endfunction

endpackage

/* sv/wbie_parser.sv */
// Per-byte frame parser: radiotap signal field and information element chain.
// Holds the frame state and the SSID capture store. Depends on wbie_pkg.
module wbie_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              byte_i,
  input  logic                    last_i,
  input  logic [7:0]              offset_i,
  output wbie_pkg::wbie_summary_t summary_o,
  output wbie_pkg::wbie_ssid_buf_t ssid_buf_o
);
  import wbie_pkg::*;

  logic [PosW-1:0]       pos_q, pos_d;
  logic                  ovf_q, ovf_d;
  logic [7:0]            start_q;
  wbie_phase_e           phase_q, phase_d, phase_eff;
  logic [7:0]            cur_id_q, cur_id_d;
  logic [7:0]            body_left_q, body_left_d;
  logic [5:0]            ssid_cnt_q, ssid_cnt_d;
  logic                  found_ssid_q, found_ssid_d;
  logic                  found_ds_q, found_ds_d;
  logic                  found_rsn_q, found_rsn_d;
  logic [7:0]            chan_q, chan_d;
  logic                  ver_nz_q, ver_nz_d;
  logic [15:0]           rt_len_q, rt_len_d;
  logic [RtPresentW-1:0] rt_present_q, rt_present_d;
  logic signed [7:0]     sig_q, sig_d;
  logic                  ssid_act_q, ssid_act_d;
  logic                  ds_act_q, ds_act_d;
  wbie_ssid_buf_t        ssid_q;
  logic                  ssid_we;
  logic [4:0]            dbm_pos, ant_pos;
  logic                  in_range, sig_ok;

  assign dbm_pos  = dbm_position(rt_present_q);
  assign ant_pos  = dbm_pos + {4'd0, rt_present_q[RtBitDbmPower]};
  assign in_range = (pos_q < PosW'(MaxFrameBytes));

  always_comb begin
    pos_d        = pos_q;
    ovf_d        = ovf_q;
    phase_d      = phase_q;
    cur_id_d     = cur_id_q;
    body_left_d  = body_left_q;
    ssid_cnt_d   = ssid_cnt_q;
    found_ssid_d = found_ssid_q;
    found_ds_d   = found_ds_q;
    found_rsn_d  = found_rsn_q;
    chan_d       = chan_q;
    ver_nz_d     = ver_nz_q;
    rt_len_d     = rt_len_q;
    rt_present_d = rt_present_q;
    sig_d        = sig_q;
    ssid_act_d   = ssid_act_q;
    ds_act_d     = ds_act_q;
    ssid_we      = 1'b0;
    phase_eff    = phase_q;
    if ((phase_q == PH_WAIT) && (pos_q == PosW'(start_q))) begin
      phase_eff = PH_ID;
    end

    if (!in_range) begin
      ovf_d = 1'b1;
    end else begin
      pos_d = pos_q + 1'b1;

      // Radiotap header fields.
      if (pos_q == PosW'(0)) begin
        ver_nz_d = (byte_i != 8'd0);
      end else if (pos_q == PosW'(2)) begin
        rt_len_d[7:0] = byte_i;
      end else if (pos_q == PosW'(3)) begin
        rt_len_d[15:8] = byte_i;
      end else if (pos_q == PosW'(4)) begin
        rt_present_d = byte_i[RtPresentW-1:0];
      end else if (pos_q >= PosW'(RtFixedLen)) begin
        if (rt_present_q[RtBitDbmPower] && (pos_q == PosW'(dbm_pos))) begin
          sig_d = byte_i;
        end
        if (rt_present_q[RtBitAntSignal] && (pos_q == PosW'(ant_pos))) begin
          sig_d = byte_i;
        end
      end

      // Information element chain.
      case (phase_eff)
        PH_ID: begin
          cur_id_d = byte_i;
          phase_d  = PH_LEN;
        end
        PH_LEN: begin
          if ((cur_id_q == IeIdSsid) && !found_ssid_q) begin
            found_ssid_d = 1'b1;
            ssid_act_d   = (byte_i != 8'd0);
          end else if ((cur_id_q == IeIdDs) && !found_ds_q) begin
            found_ds_d = 1'b1;
            ds_act_d   = (byte_i != 8'd0);
          end else if (cur_id_q == IeIdRsn) begin
            found_rsn_d = 1'b1;
          end
          body_left_d = byte_i;
          phase_d     = (byte_i != 8'd0) ? PH_BODY : PH_ID;
        end
        PH_BODY: begin
          if (ssid_act_q && (ssid_cnt_q < 6'(SsidMax))) begin
            ssid_we    = 1'b1;
            ssid_cnt_d = ssid_cnt_q + 1'b1;
          end
          if (ds_act_q) begin
            chan_d   = byte_i;
            ds_act_d = 1'b0;
          end
          body_left_d = body_left_q - 1'b1;
          if (body_left_q == 8'd1) begin
            phase_d    = PH_ID;
            ssid_act_d = 1'b0;
            ds_act_d   = 1'b0;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Summary as it stands once the current byte is taken in.
  assign sig_ok = (pos_d >= PosW'(RtFixedLen)) && !ver_nz_d && (rt_len_d <= 16'(pos_d));

  always_comb begin
    summary_o.status      = STATUS_OK;
    summary_o.ssid_length = 6'd0;
    summary_o.channel     = ChannelDefault;
    summary_o.signal_dbm  = SignalDefault;
    summary_o.rsn_present = 1'b0;
    if (ovf_d) begin
      summary_o.status = STATUS_LONG;
    end else if (pos_d < PosW'(start_q)) begin
      summary_o.status = STATUS_SHORT;
    end else begin
      summary_o.ssid_length = ssid_cnt_d;
      summary_o.channel     = chan_d;
      summary_o.rsn_present = found_rsn_d;
      if (sig_ok) begin
        summary_o.signal_dbm = sig_d;
      end
    end
  end

  always_comb begin
    ssid_buf_o = ssid_q;
    if (ssid_we) begin
      ssid_buf_o[ssid_cnt_q[SsidIdxW-1:0]] = byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && ssid_we) begin
      ssid_q[ssid_cnt_q[SsidIdxW-1:0]] <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      start_q      <= ElementOffsetReset;
      phase_q      <= PH_WAIT;
      cur_id_q     <= 8'd0;
      body_left_q  <= 8'd0;
      ssid_cnt_q   <= 6'd0;
      found_ssid_q <= 1'b0;
      found_ds_q   <= 1'b0;
      found_rsn_q  <= 1'b0;
      chan_q       <= ChannelDefault;
      ver_nz_q     <= 1'b0;
      rt_len_q     <= 16'd0;
      rt_present_q <= '0;
      sig_q        <= SignalDefault;
      ssid_act_q   <= 1'b0;
      ds_act_q     <= 1'b0;
    end else if (step_i && last_i) begin
      // End of frame: back to the clear state, offset latched for the next frame.
      pos_q        <= '0;
      ovf_q        <= 1'b0;
      start_q      <= offset_i;
      phase_q      <= PH_WAIT;
      cur_id_q     <= 8'd0;
      body_left_q  <= 8'd0;
      ssid_cnt_q   <= 6'd0;
      found_ssid_q <= 1'b0;
      found_ds_q   <= 1'b0;
      found_rsn_q  <= 1'b0;
      chan_q       <= ChannelDefault;
      ver_nz_q     <= 1'b0;
      rt_len_q     <= 16'd0;
      rt_present_q <= '0;
      sig_q        <= SignalDefault;
      ssid_act_q   <= 1'b0;
      ds_act_q     <= 1'b0;
    end else if (step_i) begin
      pos_q        <= pos_d;
      ovf_q        <= ovf_d;
      phase_q      <= phase_d;
      cur_id_q     <= cur_id_d;
      body_left_q  <= body_left_d;
      ssid_cnt_q   <= ssid_cnt_d;
      found_ssid_q <= found_ssid_d;
      found_ds_q   <= found_ds_d;
      found_rsn_q  <= found_rsn_d;
      chan_q       <= chan_d;
      ver_nz_q     <= ver_nz_d;
      rt_len_q     <= rt_len_d;
      rt_present_q <= rt_present_d;
      sig_q        <= sig_d;
      ssid_act_q   <= ssid_act_d;
      ds_act_q     <= ds_act_d;
    end
  end

endmodule

/* sv/wbie_emitter.sv */
// Result register for the beacon extractor: one summary, then the SSID bytes.
// Takes a snapshot of the frame summary and SSID bytes. Depends on wbie_pkg.
module wbie_emitter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  wbie_pkg::wbie_summary_t  summary_i,
  input  wbie_pkg::wbie_ssid_buf_t ssid_i,
  input  logic                     ready_i,
  output logic                     valid_o,
  output logic                     free_o,
  output wbie_pkg::wbie_result_t   result_o
);
  import wbie_pkg::*;

  logic           busy_q;
  logic           kind_q;
  logic [5:0]     remain_q;
  wbie_summary_t  sum_q;
  wbie_ssid_buf_t buf_q;
  logic           xfer;

  assign xfer    = busy_q && ready_i;
  assign valid_o = busy_q;
  assign free_o  = !busy_q || (ready_i && (remain_q == 6'd0));

  assign result_o.kind        = kind_q;
  assign result_o.summary     = sum_q;
  assign result_o.ssid_byte   = (kind_q == KindSsid) ? buf_q[0] : 8'd0;
  assign result_o.last_result = (remain_q == 6'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      kind_q   <= KindSummary;
      remain_q <= 6'd0;
    end else if (load_i) begin
      busy_q   <= 1'b1;
      kind_q   <= KindSummary;
      remain_q <= summary_i.ssid_length;
    end else if (xfer) begin
      if (remain_q == 6'd0) begin
        busy_q <= 1'b0;
      end else begin
        kind_q   <= KindSsid;
        remain_q <= remain_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= summary_i;
      buf_q <= ssid_i;
    end else if (xfer && (kind_q == KindSsid)) begin
      buf_q <= buf_q >> 8;
    end
  end

endmodule

/* sv/wlan_beacon_info_extractor_core.sv */
// Beacon information extractor: the summary result comes from the final input byte
// through the input register and the result register; SSID results follow one per
// cycle while m_axis_tready is high. Throughput is one input byte per cycle. A final
// byte waits in the input register only while the previous frame's burst of up to 33
// results is still draining. Reset (rst_ni low, asynchronous) clears all frame state
// and sets the element offset to 36; the SSID capture bytes are not reset.
`include "wlan_beacon_info_extractor_core_assert.svh"

module wlan_beacon_info_extractor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: one frame byte per transaction.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  // Output stream: summary result, then one result per SSID byte.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [wbie_pkg::OutTdataW-1:0] m_axis_tdata, // [1:0] status, [7:2] ssid_length,
                                      // [15:8] channel, [23:16] signal_dbm,
                                      // [24] rsn_present, [32:25] ssid_byte, rest zero
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,
  // Configuration: element_offset register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import wbie_pkg::*;

  // Input register. A byte moves on into the parser whenever it is not the
  // final byte of a frame, or when the result register can take the new frame.
  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic           in_last_q;
  logic           step;
  logic           emit_free;
  logic           emit_load;
  logic [7:0]     offset_q;
  wbie_summary_t  summary;
  wbie_ssid_buf_t ssid_buf;
  wbie_result_t   res;

  assign step          = in_valid_q && (!in_last_q || emit_free);
  assign emit_load     = step && in_last_q;
  assign s_axis_tready = !in_valid_q || step;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // The element offset is copied into the parser at each frame end, so a new
  // value applies from the frame that starts after the next final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= ElementOffsetReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      offset_q <= cfg_data_i;
    end
  end

  wbie_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .last_i     (in_last_q),
    .offset_i   (offset_q),
    .summary_o  (summary),
    .ssid_buf_o (ssid_buf)
  );

  wbie_emitter u_emitter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (emit_load),
    .summary_i (summary),
    .ssid_i    (ssid_buf),
    .ready_i   (m_axis_tready),
    .valid_o   (m_axis_tvalid),
    .free_o    (emit_free),
    .result_o  (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last_result;
  assign m_axis_tdata = {7'd0, res.ssid_byte, res.summary.rsn_present,
                         res.summary.signal_dbm, res.summary.channel,
                         res.summary.ssid_length, res.summary.status};

  // An error summary carries no SSID bytes, so it closes the burst.
  `WBIE_ASSERT(a_error_is_last,
    !m_axis_tvalid || (res.summary.status == STATUS_OK) || m_axis_tlast,
    "error summary is not the final result")

  // The summary is the last result exactly when the SSID is empty.
  `WBIE_ASSERT(a_summary_last,
    !m_axis_tvalid || (res.kind != KindSummary)
      || (m_axis_tlast == (res.summary.ssid_length == 6'd0)),
    "summary end mark disagrees with ssid_length")

  // A result that is not the last is always followed by an SSID result.
  `WBIE_ASSERT_NEXT(a_burst_continues,
    m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && (res.kind == KindSsid),
    "burst broken before its final result")

  // A new frame is handed over only when no unfinished burst would be lost.
  `WBIE_ASSERT(a_no_overrun,
    !emit_load || !m_axis_tvalid || (m_axis_tready && m_axis_tlast),
    "frame summary loaded over a pending burst")

endmodule

/* tb/wbie_tb_pkg.sv */
// Scoreboard for the beacon information extractor testbench. It predicts the
// summary and SSID results of every frame and checks the output stream against them.
// Depends on wbie_pkg for sizes, element codes, enums and the result struct.
package wbie_tb_pkg;
  import wbie_pkg::*;

  class beacon_result_scoreboard;
    // Element offset register and the value latched for the frame in progress.
    logic [7:0]   offset_reg;
    int unsigned  chain_start;
    int unsigned  byte_pos;
    bit           overflowed;
    wbie_phase_e  phase;
    logic [7:0]   ie_id;
    logic [7:0]   body_left;
    logic [7:0]   ssid_bytes [SsidMax];
    int unsigned  ssid_count;
    bit           ssid_seen;
    bit           ds_seen;
    bit           rsn_seen;
    bit           ssid_capture;
    bit           ds_capture;
    logic [7:0]   channel;
    logic [7:0]   rt_version;
    logic [15:0]  rt_length;
    logic [31:0]  rt_present;
    logic [7:0]   signal;
    wbie_result_t expected_results[$];
    int unsigned  mismatches;

    function new();
      offset_reg = ElementOffsetReset;
      mismatches = 0;
      start_frame();
    endfunction

    function void start_frame();
      chain_start  = offset_reg;
      byte_pos     = 0;
      overflowed   = 1'b0;
      phase        = PH_WAIT;
      ie_id        = '0;
      body_left    = '0;
      ssid_count   = 0;
      ssid_seen    = 1'b0;
      ds_seen      = 1'b0;
      rsn_seen     = 1'b0;
      ssid_capture = 1'b0;
      ds_capture   = 1'b0;
      channel      = ChannelDefault;
      rt_version   = '0;
      rt_length    = '0;
      rt_present   = '0;
      signal       = SignalDefault;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    // Called for every accepted input byte; on the final byte it queues the
    // summary and the SSID results of the frame.
    function void take_byte(logic [7:0] b, logic last);
      int unsigned   dbm_at;
      int unsigned   k;
      wbie_summary_t summary;
      wbie_result_t  res;
      if (byte_pos >= MaxFrameBytes) begin
        overflowed = 1'b1;
      end else begin
        // Radiotap view of the byte.
        if (byte_pos == 0) begin
          rt_version = b;
        end else if (byte_pos == 2) begin
          rt_length[7:0] = b;
        end else if (byte_pos == 3) begin
          rt_length[15:8] = b;
        end else if (byte_pos >= 4 && byte_pos < 8) begin
          rt_present[8*(byte_pos-4) +: 8] = b;
        end else if (byte_pos >= 8) begin
          dbm_at = 8 + (rt_present[0] ? 8 : 0) + int'(rt_present[1]) + int'(rt_present[2])
                 + (rt_present[3] ? 4 : 0) + (rt_present[4] ? 2 : 0);
          if (rt_present[RtBitDbmPower] && byte_pos == dbm_at) signal = b;
          if (rt_present[RtBitAntSignal] && byte_pos == dbm_at + int'(rt_present[RtBitDbmPower]))
            signal = b;
        end
        // Element chain view of the byte.
        if (phase == PH_WAIT && byte_pos == chain_start) phase = PH_ID;
        case (phase)
          PH_ID: begin
            ie_id = b;
            phase = PH_LEN;
          end
          PH_LEN: begin
            if (ie_id == IeIdSsid && !ssid_seen) begin
              ssid_seen = 1'b1;
              ssid_capture = (b != 0);
            end else if (ie_id == IeIdDs && !ds_seen) begin
              ds_seen = 1'b1;
              ds_capture = (b != 0);
            end else if (ie_id == IeIdRsn) begin
              rsn_seen = 1'b1;
            end
            body_left = b;
            phase = (b != 0) ? PH_BODY : PH_ID;
          end
          PH_BODY: begin
            if (ssid_capture && ssid_count < SsidMax) begin
              ssid_bytes[ssid_count] = b;
              ssid_count++;
            end
            if (ds_capture) begin
              channel = b;
              ds_capture = 1'b0;
            end
            body_left--;
            if (body_left == 0) begin
              phase = PH_ID;
              ssid_capture = 1'b0;
              ds_capture = 1'b0;
            end
          end
          default: ;
        endcase
        byte_pos++;
      end
      if (!last) return;

      summary.status      = STATUS_OK;
      summary.ssid_length = '0;
      summary.channel     = ChannelDefault;
      summary.signal_dbm  = SignalDefault;
      summary.rsn_present = 1'b0;
      if (overflowed) begin
        summary.status = STATUS_LONG;
      end else if (byte_pos < chain_start) begin
        summary.status = STATUS_SHORT;
      end else begin
        summary.ssid_length = 6'(ssid_count);
        summary.channel     = channel;
        summary.rsn_present = rsn_seen;
        if (byte_pos >= RtFixedLen && rt_version == 0 && rt_length <= byte_pos)
          summary.signal_dbm = signal;
      end
      for (k = 0; k <= summary.ssid_length; k++) begin
        res.kind        = (k == 0) ? KindSummary : KindSsid;
        res.summary     = summary;
        res.ssid_byte   = (k == 0) ? 8'd0 : ssid_bytes[k-1];
        res.last_result = (k == summary.ssid_length);
        expected_results.push_back(res);
      end
      start_frame();
    endfunction

    function void report(string what, logic [39:0] exp_v, logic [39:0] act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, actual %0h", what, exp_v, act_v);
    endfunction

    // Called for every accepted output transaction.
    function void match_result(logic [OutTdataW-1:0] data, logic kind, logic last);
      wbie_result_t exp_r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing expected: tdata %0h, kind %0b, last %0b",
                   data, kind, last);
        return;
      end
      exp_r = expected_results.pop_front();
      if (kind !== exp_r.kind) report("kind", exp_r.kind, kind);
      if (data[1:0] !== exp_r.summary.status) report("status", exp_r.summary.status, data[1:0]);
      if (data[7:2] !== exp_r.summary.ssid_length)
        report("ssid_length", exp_r.summary.ssid_length, data[7:2]);
      if (data[15:8] !== exp_r.summary.channel)
        report("channel", exp_r.summary.channel, data[15:8]);
      if (data[23:16] !== exp_r.summary.signal_dbm)
        report("signal_dbm", unsigned'(exp_r.summary.signal_dbm), data[23:16]);
      if (data[24] !== exp_r.summary.rsn_present)
        report("rsn_present", exp_r.summary.rsn_present, data[24]);
      if (data[32:25] !== exp_r.ssid_byte) report("ssid_byte", exp_r.ssid_byte, data[32:25]);
      if (data[OutTdataW-1:33] !== '0) report("tdata padding", '0, data[OutTdataW-1:33]);
      if (last !== exp_r.last_result) report("last_result", exp_r.last_result, last);
    endfunction
  endclass

endpackage

/* tb/tb_wlan_beacon_info_extractor_core.sv */
// Testbench top for wlan_beacon_info_extractor_core: streams radiotap and element
// frames into the block and checks every output transaction against the scoreboard.
// Depends on wbie_pkg and wbie_tb_pkg.
module tb_wlan_beacon_info_extractor_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wbie_pkg::*;
  import wbie_tb_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 8;
  // Cycles without any transaction before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off below.
  localparam int QuietLimit   = 5000;
  localparam int HoldCycles   = 400;
  // Idle cycles before a register write, well past the block's latency.
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 20;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [7:0]           cfg_data_i = '0;

  beacon_result_scoreboard sb = new();

  wlan_beacon_info_extractor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Receiver side. Normally it drops tready at random with the current idle
  // percentage. A toggle of hold_req starts a long hold-off that this process
  // counts down on its own, so the block backs up into its input.
  int unsigned recv_idle_pct = 67;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned hold_left = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HoldCycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor and watchdog. All three channels are sampled at the rising edge,
  // before any nonblocking update of that edge lands. A register write reaches
  // the scoreboard at once; it only affects the frame after the next final byte.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.offset_reg = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready)
        sb.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata, s_axis_tlast);
      if ((cfg_valid_i && cfg_ready_o) || (m_axis_tvalid && m_axis_tready) ||
          (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
        $display("tb_wlan_beacon_info_extractor_core: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus state. chain_start follows the block's latching rule: a new
  // offset is only used by the frame that starts after the next final byte.
  int unsigned send_idle_pct = 6;
  int unsigned chain_start = ElementOffsetReset;
  logic [7:0]  offset_setting = ElementOffsetReset;
  int unsigned bytes_sent = 0;
  logic [7:0]  frame_q[$];

  // Radiotap header (when the chain starts past it), then random fixed fields
  // up to the start of the element chain.
  function automatic void begin_frame(input logic [7:0] version, input logic [15:0] rt_len,
                                      input logic [31:0] present);
    frame_q = {};
    if (chain_start >= RtFixedLen)
      frame_q = {version, 8'($urandom), rt_len[7:0], rt_len[15:8],
                 present[7:0], present[15:8], present[23:16], present[31:24]};
    while (frame_q.size() < chain_start) frame_q.push_back(8'($urandom));
  endfunction

  // One element; a body shorter than the length field cuts the frame there,
  // so it must be the last element added.
  function automatic void add_element(input logic [7:0] id, input logic [7:0] len,
                                      input int unsigned body_bytes);
    frame_q.push_back(id);
    frame_q.push_back(len);
    repeat (body_bytes) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void noise_frame(input int unsigned len);
    frame_q = {};
    repeat (len) frame_q.push_back(8'($urandom));
  endfunction

  // Streams frame_q, one transaction per byte, with tlast on the final byte.
  // tvalid stays high from one byte to the next unless the sender idles.
  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= frame_q[i];
      s_axis_tlast  <= (i == frame_q.size() - 1);
      do @(posedge clk_i); while (!s_axis_tready);
    end
    bytes_sent += frame_q.size();
    chain_start = offset_setting;
  endtask

  // Stops offering input until every queued result has come out. The
  // scoreboard is read on the falling edge to stay clear of the monitor.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (sb.outstanding() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [7:0] value);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    offset_setting = value;
  endtask

  // Mostly well-formed frames with random content; the rest are frames that end
  // before the chain starts, plain noise, or frames cut off at a random byte.
  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  id;
    pick = $urandom_range(99);
    if (pick < 12 && chain_start > 1) begin
      noise_frame($urandom_range(chain_start - 1, 1));
    end else if (pick < 24) begin
      noise_frame($urandom_range(80, 1));
    end else begin
      begin_frame(($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00,
                  16'($urandom_range(chain_start + 48, 0)),
                  ($urandom_range(3) == 0) ? $urandom : {25'd0, 7'($urandom)});
      repeat ($urandom_range(5, 1)) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          id  = IeIdSsid;
          len = ($urandom_range(3) == 0) ? $urandom_range(40, 33) : $urandom_range(32, 0);
        end else if (pick < 50) begin
          id  = IeIdDs;
          len = $urandom_range(2, 0);
        end else if (pick < 65) begin
          id  = IeIdRsn;
          len = $urandom_range(20, 0);
        end else begin
          id  = 8'($urandom);
          len = $urandom_range(12, 0);
        end
        add_element(id, 8'(len), len);
      end
      if ($urandom_range(4) == 0) begin
        cut = $urandom_range(frame_q.size(), 1);
        frame_q = frame_q[0:cut-1];
      end
    end
    send_frame();
  endtask

  task automatic random_run(input int unsigned target_bytes);
    int unsigned start_bytes;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < target_bytes) random_frame();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Move the chain right behind the radiotap header to keep frames short.
    // The first frame still runs at the reset offset, since a write only applies
    // from the frame after the next final byte.
    write_offset(8'd8);

    // Antenna signal and dBm power both present, so the antenna byte must win;
    // SSID, DS and RSN all present.
    begin_frame(8'h00, 16'd8, 32'h0000_0060);
    add_element(IeIdSsid, 8'd4, 4);
    add_element(IeIdDs, 8'd1, 1);
    add_element(IeIdRsn, 8'd2, 2);
    send_frame();
    // Every skipped radiotap field present, dBm power only; full 32-byte SSID.
    begin_frame(8'h00, 16'd8, 32'h0000_003F);
    add_element(IeIdSsid, 8'd32, 32);
    add_element(IeIdDs, 8'd1, 1);
    send_frame();
    // Bad radiotap version, and an SSID longer than the store keeps.
    begin_frame(8'h01, 16'd8, 32'h0000_0040);
    add_element(IeIdSsid, 8'd40, 40);
    send_frame();
    // Radiotap length past the frame end; empty first SSID and DS elements
    // hide the later ones; a long element cut off by the end of the frame.
    begin_frame(8'h00, 16'hFFFF, 32'hFFFF_FFFF);
    add_element(IeIdSsid, 8'd0, 0);
    add_element(IeIdSsid, 8'd5, 5);
    add_element(IeIdDs, 8'd0, 0);
    add_element(IeIdDs, 8'd1, 1);
    add_element(8'hFF, 8'hFF, 3);
    send_frame();
    // SSID body cut short by the end of the frame.
    begin_frame(8'h00, 16'd8, 32'h0000_0020);
    add_element(IeIdSsid, 8'd10, 4);
    send_frame();
    // DS element whose channel byte never arrives.
    begin_frame(8'h00, 16'd8, 32'h0);
    add_element(IeIdDs, 8'd1, 0);
    send_frame();
    // Empty RSN element, then an element id with no length byte.
    begin_frame(8'h00, 16'd8, 32'h0);
    add_element(IeIdRsn, 8'd0, 0);
    frame_q.push_back(IeIdSsid);
    send_frame();
    // Frames ending before the chain and exactly at it.
    noise_frame(1);
    send_frame();
    noise_frame(chain_start - 1);
    send_frame();
    begin_frame(8'h00, 16'd0, 32'h0);
    send_frame();
    drain_results();

    // Receiver holds off while the sender keeps offering frames, so finished
    // frames pile up and the block stops taking input; then the sender pauses
    // until every result is out.
    hold_req <= ~hold_req;
    repeat (3) random_frame();
    drain_results();

    // Offset at its lower extreme.
    write_offset(8'd0);
    random_run(24);

    // Sender idles a lot, receiver rarely.
    send_idle_pct = 67;
    recv_idle_pct <= 6;
    write_offset(8'($urandom_range(40, 1)));
    random_run(40);

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_offset(8'd8);
    random_run(24);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_wlan_beacon_info_extractor_core: clean");
    end else begin
      $display("tb_wlan_beacon_info_extractor_core: errors");
    end
    $finish;
  end

endmodule
